// ===== sv/gurr_pkg.sv =====
// shared types, codes and defaults for the grouped undo/redo ring
package gurr_pkg;

  // default sizes
  localparam int DEF_RING_DEPTH  = 64;
  localparam int DEF_MAP_ENTRIES = 4096;
  localparam int DEF_TILE_BITS   = 16;

  // fixed field widths of the request and result items
  localparam int CMD_W  = 3;
  localparam int ADDR_W = 12;
  localparam int VAL_W  = 16;
  localparam int STAT_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EDIT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNDO  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REDO  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_CUT   = 2'd2;

  // record flag codes
  localparam logic [1:0] FLAG_FREE   = 2'd0;
  localparam logic [1:0] FLAG_DONE   = 2'd1;
  localparam logic [1:0] FLAG_UNDONE = 2'd2;

  // record group marks
  localparam logic [1:0] GRP_NONE  = 2'd0;
  localparam logic [1:0] GRP_BEGIN = 2'd1;
  localparam logic [1:0] GRP_IN    = 2'd2;
  localparam logic [1:0] GRP_END   = 2'd3;

  // saturation limits of the group counters
  localparam logic [7:0] NEST_MAX = 8'd255;
  localparam logic [6:0] GLEN_MAX = 7'd127;

  // request payload
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] tile_address;
    logic [VAL_W-1:0]  tile_value;
  } cmd_item_t;

  // result payload
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] out_address;
    logic [VAL_W-1:0]  out_value;
    logic              last;
  } res_item_t;

  // per-record state kept in the meta memory
  typedef struct packed {
    logic [1:0] flag;
    logic [1:0] grp;
  } meta_t;

endpackage

// ===== sv/gurr_ram.sv =====
// generic single-write, single-read memory with registered read data
module gurr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gurr_mod_unit.sv =====
// reduction of a tile address modulo the map size by reciprocal multiplication
module gurr_mod_unit #(
  parameter int MAP_ENTRIES = gurr_pkg::DEF_MAP_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gurr_pkg::ADDR_W-1:0] din,
  output logic                        busy,
  output logic [gurr_pkg::ADDR_W-1:0] rem
);
  import gurr_pkg::*;

  // only sizes below the address range that are not powers of two need steps
  localparam bit NEED_MOD = (MAP_ENTRIES < (1 << ADDR_W)) &&
                            ((MAP_ENTRIES & (MAP_ENTRIES - 1)) != 0);

  generate
    if (NEED_MOD) begin : g_iter
      // rounded-up reciprocal, exact quotient for every address value
      localparam int     L_BITS = $clog2(MAP_ENTRIES);
      localparam int     SHIFT  = ADDR_W + L_BITS;
      localparam longint RECIP  = ((longint'(1) << SHIFT) + MAP_ENTRIES - 1) / MAP_ENTRIES;
      localparam int     PROD_W = 2 * ADDR_W + 1;

      logic [ADDR_W-1:0] x;
      logic [ADDR_W-1:0] quot;
      logic [PROD_W-1:0] prod;
      logic              phase;

      assign prod = PROD_W'(x) * PROD_W'(RECIP);

      // busy while the quotient is formed first and then the remainder
      always_ff @(posedge clk) begin
        if (rst) begin
          busy  <= 1'b0;
          phase <= 1'b0;
        end else if (start) begin
          busy  <= 1'b1;
          phase <= 1'b0;
        end else if (busy) begin
          phase <= 1'b1;
          if (phase) begin
            busy <= 1'b0;
          end
        end
      end

      // quotient by multiply and shift, remainder by multiply and subtract
      always_ff @(posedge clk) begin
        if (start) begin
          x <= din;
        end else if (busy && !phase) begin
          quot <= ADDR_W'(prod >> SHIFT);
        end else if (busy) begin
          rem <= x - ADDR_W'(quot * ADDR_W'(MAP_ENTRIES));
        end
      end
    end else begin : g_direct
      // the tile memory index truncation already gives the remainder
      assign busy = 1'b0;

      always_ff @(posedge clk) begin
        if (start) begin
          rem <= din;
        end
      end
    end
  endgenerate

endmodule

// ===== sv/grouped_undo_redo_ring.sv =====
// top level: tile memory, undo record ring and the command sequencer
//
// Requests arrive on cmd (valid/ready) and carry a command, a tile address
// and a tile value. Results leave on res (valid/ready); a read gives one
// result, an undo or redo gives one result per restored record with last
// set on the final one (one empty result if nothing is restored), and edit,
// begin and end give none. One request is worked on at a time; cmd_ready is
// high only while the sequencer is idle. A read is reduced, decoded and read
// from the tile memory before its result goes to the output register; an end
// that closes a group holding edits passes a further state that marks the
// newest record. Each record of an undo or redo passes the chain of record
// read, tile read and write-back through the memories. Map sizes below 4096
// that are not a power of two need the quotient and remainder steps of the
// address reduction unit.
// After reset the tile memory is swept to zero, one word per cycle, and no
// request is accepted during the sweep. Results wait in an output register;
// while it is full the sequencer holds before the next result, and a request
// that gives no result is still taken.
module grouped_undo_redo_ring #(
  parameter int RING_DEPTH  = gurr_pkg::DEF_RING_DEPTH,
  parameter int MAP_ENTRIES = gurr_pkg::DEF_MAP_ENTRIES,
  parameter int TILE_BITS   = gurr_pkg::DEF_TILE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gurr_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output gurr_pkg::res_item_t res
);
  import gurr_pkg::*;

  localparam int RI_BITS = $clog2(RING_DEPTH);
  localparam int TA_BITS = $clog2(MAP_ENTRIES);
  localparam int INFO_W  = TA_BITS + TILE_BITS;

  localparam logic [RI_BITS-1:0] LAST_SLOT = RI_BITS'(RING_DEPTH - 1);
  localparam logic [TA_BITS-1:0] LAST_TILE = TA_BITS'(MAP_ENTRIES - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REDUCE = 4'd2;
  localparam logic [3:0] S_DECODE = 4'd3;
  localparam logic [3:0] S_READ_D = 4'd4;
  localparam logic [3:0] S_EDIT_D = 4'd5;
  localparam logic [3:0] S_END_D  = 4'd6;
  localparam logic [3:0] S_W_CHK  = 4'd7;
  localparam logic [3:0] S_W_INFO = 4'd8;
  localparam logic [3:0] S_W_TILE = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  // control registers
  logic [3:0]         state, state_next;
  logic [TA_BITS-1:0] clr_idx, clr_idx_next;
  logic [RI_BITS-1:0] top, top_next;
  logic [7:0]         nest, nest_next;
  logic               gopen, gopen_next;
  logic [6:0]         glen, glen_next;
  logic               first, first_next;
  logic [RING_DEPTH-1:0] vld;
  logic               vld_set;
  logic [RI_BITS-1:0] vld_idx;

  // payload registers
  cmd_item_t          item, item_next;
  logic [RI_BITS-1:0] cursor, cursor_next;
  logic [1:0]         g_reg, g_next;
  logic [TA_BITS-1:0] rec_a, rec_a_next;
  logic [TILE_BITS-1:0] rec_v, rec_v_next;
  res_item_t          pend, pend_next;
  logic               res_load;

  // memory ports
  logic                 tile_we;
  logic [TA_BITS-1:0]   tile_wa, tile_ra;
  logic [TILE_BITS-1:0] tile_wd, tile_rd;
  logic                 info_we;
  logic [RI_BITS-1:0]   info_wa, info_ra;
  logic [INFO_W-1:0]    info_wd, info_rd;
  logic                 meta_we;
  logic [RI_BITS-1:0]   meta_wa, meta_ra;
  meta_t                meta_wd, meta_rd;

  // address reduction unit
  logic                 mod_start, mod_busy;
  logic [ADDR_W-1:0]    mod_rem;
  logic [TA_BITS-1:0]   addr_red;

  // walk helpers
  logic               is_undo;
  logic [RI_BITS-1:0] top_succ, cur_step;
  logic [1:0]         want_flag, new_flag;
  logic               walk_ok, more;
  logic [TA_BITS-1:0] info_addr;

  gurr_mod_unit #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .din  (cmd.tile_address),
    .busy (mod_busy),
    .rem  (mod_rem)
  );

  gurr_ram #(
    .WIDTH(TILE_BITS),
    .DEPTH(MAP_ENTRIES)
  ) u_tile_ram (
    .clk  (clk),
    .we   (tile_we),
    .waddr(tile_wa),
    .wdata(tile_wd),
    .raddr(tile_ra),
    .rdata(tile_rd)
  );

  gurr_ram #(
    .WIDTH(INFO_W),
    .DEPTH(RING_DEPTH)
  ) u_info_ram (
    .clk  (clk),
    .we   (info_we),
    .waddr(info_wa),
    .wdata(info_wd),
    .raddr(info_ra),
    .rdata(info_rd)
  );

  gurr_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(RING_DEPTH)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_wa),
    .wdata(meta_wd),
    .raddr(meta_ra),
    .rdata(meta_rd)
  );

  // ring index and direction helpers
  assign addr_red  = TA_BITS'(mod_rem);
  assign is_undo   = (item.command == CMD_UNDO);
  assign top_succ  = (top == LAST_SLOT) ? '0 : top + 1'b1;
  assign want_flag = is_undo ? FLAG_DONE : FLAG_UNDONE;
  assign new_flag  = is_undo ? FLAG_UNDONE : FLAG_DONE;
  assign info_addr = info_rd[TILE_BITS +: TA_BITS];
  assign walk_ok   = vld[cursor] && (meta_rd.flag == want_flag);
  assign more      = (g_reg == GRP_IN) ||
                     (is_undo ? (g_reg == GRP_END) : (g_reg == GRP_BEGIN));

  always_comb begin
    if (is_undo) begin
      cur_step = (cursor == '0) ? LAST_SLOT : cursor - 1'b1;
    end else begin
      cur_step = (cursor == LAST_SLOT) ? '0 : cursor + 1'b1;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    top_next     = top;
    nest_next    = nest;
    gopen_next   = gopen;
    glen_next    = glen;
    first_next   = first;
    item_next    = item;
    cursor_next  = cursor;
    g_next       = g_reg;
    rec_a_next   = rec_a;
    rec_v_next   = rec_v;
    pend_next    = pend;
    res_load     = 1'b0;
    mod_start    = 1'b0;
    vld_set      = 1'b0;
    vld_idx      = cursor;
    tile_we      = 1'b0;
    tile_wa      = addr_red;
    tile_wd      = TILE_BITS'(item.tile_value);
    tile_ra      = addr_red;
    info_we      = 1'b0;
    info_wa      = cursor;
    info_wd      = {addr_red, tile_rd};
    info_ra      = cursor;
    meta_we      = 1'b0;
    meta_wa      = cursor;
    meta_wd      = '{flag: FLAG_DONE, grp: GRP_NONE};
    meta_ra      = cursor;

    case (state)
      // zero the tile memory after reset
      S_CLEAR: begin
        tile_we      = 1'b1;
        tile_wa      = clr_idx;
        tile_wd      = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_TILE) begin
          state_next = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (cmd_valid) begin
          item_next  = cmd;
          mod_start  = 1'b1;
          state_next = S_REDUCE;
        end
      end

      // wait for the address reduction
      S_REDUCE: begin
        if (!mod_busy) begin
          state_next = S_DECODE;
        end
      end

      // act on the command
      S_DECODE: begin
        case (item.command)
          CMD_READ: begin
            tile_ra    = addr_red;
            state_next = S_READ_D;
          end
          CMD_EDIT: begin
            tile_ra    = addr_red;
            state_next = S_EDIT_D;
          end
          CMD_BEGIN: begin
            if (nest == '0) begin
              gopen_next = 1'b1;
              glen_next  = '0;
            end
            if (nest != NEST_MAX) begin
              nest_next = nest + 1'b1;
            end
            state_next = S_IDLE;
          end
          CMD_END: begin
            state_next = S_IDLE;
            if (nest != '0) begin
              nest_next = nest - 1'b1;
              if (nest == 8'd1) begin
                if (glen != '0) begin
                  meta_ra    = top;
                  state_next = S_END_D;
                end else begin
                  gopen_next = 1'b0;
                  glen_next  = '0;
                end
              end
            end
          end
          CMD_UNDO: begin
            cursor_next = top;
            meta_ra     = top;
            first_next  = 1'b1;
            state_next  = S_W_CHK;
          end
          CMD_REDO: begin
            cursor_next = top_succ;
            meta_ra     = top_succ;
            first_next  = 1'b1;
            state_next  = S_W_CHK;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // read result
      S_READ_D: begin
        pend_next  = '{status: ST_OK, out_address: ADDR_W'(addr_red),
                       out_value: VAL_W'(tile_rd), last: 1'b1};
        state_next = S_EMIT;
      end

      // log the old value and write the new one
      S_EDIT_D: begin
        info_we = 1'b1;
        info_wa = top_succ;
        info_wd = {addr_red, tile_rd};
        meta_we = 1'b1;
        meta_wa = top_succ;
        if (gopen) begin
          meta_wd = '{flag: FLAG_DONE, grp: (glen != '0) ? GRP_IN : GRP_BEGIN};
          if (glen != GLEN_MAX) begin
            glen_next = glen + 1'b1;
          end
        end else begin
          meta_wd = '{flag: FLAG_DONE, grp: GRP_NONE};
        end
        vld_set    = 1'b1;
        vld_idx    = top_succ;
        tile_we    = 1'b1;
        tile_wa    = addr_red;
        tile_wd    = TILE_BITS'(item.tile_value);
        top_next   = top_succ;
        state_next = S_IDLE;
      end

      // close the outermost group on the newest record
      S_END_D: begin
        meta_we    = 1'b1;
        meta_wa    = top;
        meta_wd    = '{flag: vld[top] ? meta_rd.flag : FLAG_FREE,
                       grp: (glen >= 7'd2) ? GRP_END : GRP_NONE};
        vld_set    = 1'b1;
        vld_idx    = top;
        gopen_next = 1'b0;
        glen_next  = '0;
        state_next = S_IDLE;
      end

      // check the next record of the walk
      S_W_CHK: begin
        if (!walk_ok) begin
          if (first) begin
            pend_next = '{status: ST_EMPTY, out_address: '0, out_value: '0,
                          last: 1'b1};
          end else begin
            pend_next.status = ST_CUT;
            pend_next.last   = 1'b1;
          end
          state_next = S_EMIT;
        end else begin
          g_next = meta_rd.grp;
          if (first) begin
            info_ra    = cursor;
            state_next = S_W_INFO;
          end else begin
            state_next = S_EMIT;
          end
        end
      end

      // record data in hand, fetch the tile it names
      S_W_INFO: begin
        rec_a_next = info_addr;
        rec_v_next = info_rd[TILE_BITS-1:0];
        tile_ra    = info_addr;
        state_next = S_W_TILE;
      end

      // swap tile and saved value, advance the walk
      S_W_TILE: begin
        tile_we   = 1'b1;
        tile_wa   = rec_a;
        tile_wd   = rec_v;
        info_we   = 1'b1;
        info_wa   = cursor;
        info_wd   = {rec_a, tile_rd};
        meta_we   = 1'b1;
        meta_wa   = cursor;
        meta_wd   = '{flag: new_flag, grp: g_reg};
        vld_set   = 1'b1;
        vld_idx   = cursor;
        top_next  = is_undo ? cur_step : cursor;
        pend_next = '{status: ST_OK, out_address: ADDR_W'(rec_a),
                      out_value: VAL_W'(rec_v), last: !more};
        if (more) begin
          cursor_next = cur_step;
          meta_ra     = cur_step;
          first_next  = 1'b0;
          state_next  = S_W_CHK;
        end else begin
          state_next = S_EMIT;
        end
      end

      // hand the pending result to the output register
      S_EMIT: begin
        if (!res_valid || res_ready) begin
          res_load = 1'b1;
          if (pend.last) begin
            state_next = S_IDLE;
          end else begin
            info_ra    = cursor;
            state_next = S_W_INFO;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      top       <= LAST_SLOT;
      nest      <= '0;
      gopen     <= 1'b0;
      glen      <= '0;
      first     <= 1'b0;
      vld       <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      top     <= top_next;
      nest    <= nest_next;
      gopen   <= gopen_next;
      glen    <= glen_next;
      first   <= first_next;
      if (vld_set) begin
        vld[vld_idx] <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    item   <= item_next;
    cursor <= cursor_next;
    g_reg  <= g_next;
    rec_a  <= rec_a_next;
    rec_v  <= rec_v_next;
    pend   <= pend_next;
    if (res_load) begin
      res <= pend;
    end
  end

endmodule

// ===== dv/grouped_undo_redo_ring_tb.sv =====
`timescale 1ns / 100ps
// testbench for the grouped undo/redo ring: directed table and random bursts against a predictor
module grouped_undo_redo_ring_tb;
  import gurr_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RING           = DEF_RING_DEPTH;
  localparam int MAP            = DEF_MAP_ENTRIES;
  localparam int RANDOM_ITEMS   = 340;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_PRINTED    = 50;
  localparam int DIRECTED_ROWS  = 26;

  // command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

  localparam res_item_t UNTYPED = '0;

  typedef struct {
    cmd_item_t req;
    bit        typed;
    res_item_t want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_item_t cmd       = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res;

  bit        calm         = 1'b0;
  int        error_count  = 0;
  int        results_seen = 0;
  int        items_taken  = 0;
  int        quiet_cycles = 0;
  res_item_t pending_results[$];
  logic [ADDR_W-1:0] hot_addr [8];

  // shadow of the tile memory and the undo ring
  logic [VAL_W-1:0]  shadow_tiles [MAP];
  logic [ADDR_W-1:0] slot_addr    [RING];
  logic [VAL_W-1:0]  slot_saved   [RING];
  logic [1:0]        slot_flag    [RING];
  logic [1:0]        slot_mark    [RING];
  int                top_slot;
  logic [7:0]        nest_depth;
  bit                group_active;
  logic [6:0]        group_edits;

  // directed requests; typed results only where they are obvious
  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{'{CMD_READ,   12'h000, 16'h0000}, 1'b1, '{ST_OK,    12'h000, 16'h0000, 1'b1}},
    '{'{CMD_READ,   12'hFFF, 16'h0000}, 1'b1, '{ST_OK,    12'hFFF, 16'h0000, 1'b1}},
    '{'{CMD_UNDO,   12'h000, 16'h0000}, 1'b1, '{ST_EMPTY, 12'h000, 16'h0000, 1'b1}},
    '{'{CMD_REDO,   12'h000, 16'h0000}, 1'b1, '{ST_EMPTY, 12'h000, 16'h0000, 1'b1}},
    '{'{CMD_END,    12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_EDIT,   12'hFFF, 16'hFFFF}, 1'b0, UNTYPED},
    '{'{CMD_READ,   12'hFFF, 16'h0000}, 1'b1, '{ST_OK,    12'hFFF, 16'hFFFF, 1'b1}},
    '{'{CMD_UNDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_BEGIN,  12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_BEGIN,  12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_EDIT,   12'h0A5, 16'h1234}, 1'b0, UNTYPED},
    '{'{CMD_EDIT,   12'h5A0, 16'hABCD}, 1'b0, UNTYPED},
    '{'{CMD_END,    12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_END,    12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_UNDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_REDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_BEGIN,  12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_EDIT,   12'h3C3, 16'h5555}, 1'b0, UNTYPED},
    '{'{CMD_END,    12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_BEGIN,  12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_END,    12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_UNDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_UNDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_EDIT,   12'h777, 16'h0F0F}, 1'b0, UNTYPED},
    '{'{CMD_REDO,   12'h000, 16'h0000}, 1'b0, UNTYPED},
    '{'{CMD_RSVD_B, 12'hFFF, 16'hFFFF}, 1'b0, UNTYPED}
  };

  grouped_undo_redo_ring i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // clock
  always #(HALF_PERIOD) clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    res_ready <= calm || ($urandom_range(0, 99) >= 23);
  end

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[tb] %0t: %s", $time, what);
    end
  endtask

  function automatic int ring_next(input int i);
    return (i == RING - 1) ? 0 : i + 1;
  endfunction

  // slot an undo or a redo looks at next
  function automatic int peek_slot(input bit forward);
    return forward ? ring_next(top_slot) : top_slot;
  endfunction

  // undo (backward) or redo (forward) through a whole group, one result per record
  function automatic void walk_group(input bit forward);
    logic [1:0]       need;
    logic [1:0]       mark;
    logic [VAL_W-1:0] held;
    res_item_t        item;
    int               r;
    int               n;
    bit               more;
    need = forward ? FLAG_UNDONE : FLAG_DONE;
    if (slot_flag[peek_slot(forward)] != need) begin
      item = '0;
      item.status = ST_EMPTY;
      item.last = 1'b1;
      pending_results.push_back(item);
      return;
    end
    n = 0;
    forever begin
      r = peek_slot(forward);
      mark = slot_mark[r];
      // swap tile and saved value
      held = shadow_tiles[slot_addr[r]];
      shadow_tiles[slot_addr[r]] = slot_saved[r];
      slot_saved[r] = held;
      more = forward ? (mark == GRP_IN || mark == GRP_BEGIN)
                     : (mark == GRP_IN || mark == GRP_END);
      slot_flag[r] = forward ? FLAG_DONE : FLAG_UNDONE;
      top_slot = forward ? r : ((r == 0) ? RING - 1 : r - 1);
      item = '{ST_OK, slot_addr[r], shadow_tiles[slot_addr[r]], 1'b0};
      n++;
      if (!more) begin
        item.last = 1'b1;
        break;
      end
      // group wants more but the ring runs out or the next record is stale
      if (n == RING || slot_flag[peek_slot(forward)] != need) begin
        item.status = ST_CUT;
        item.last = 1'b1;
        break;
      end
      pending_results.push_back(item);
    end
    pending_results.push_back(item);
  endfunction

  // expected results of one accepted request
  function automatic void predict_step(input cmd_item_t req);
    res_item_t item;
    int        slot;
    case (req.command)
      CMD_READ: begin
        item = '{ST_OK, req.tile_address, shadow_tiles[req.tile_address], 1'b1};
        pending_results.push_back(item);
      end
      CMD_EDIT: begin
        slot = ring_next(top_slot);
        top_slot = slot;
        slot_addr[slot] = req.tile_address;
        slot_saved[slot] = shadow_tiles[req.tile_address];
        slot_flag[slot] = FLAG_DONE;
        if (group_active) begin
          slot_mark[slot] = (group_edits > 0) ? GRP_IN : GRP_BEGIN;
          if (group_edits < GLEN_MAX) group_edits++;
        end else begin
          slot_mark[slot] = GRP_NONE;
        end
        shadow_tiles[req.tile_address] = req.tile_value;
      end
      CMD_BEGIN: begin
        if (nest_depth == 0) begin
          group_active = 1'b1;
          group_edits = '0;
        end
        if (nest_depth < NEST_MAX) nest_depth++;
      end
      CMD_END: begin
        if (nest_depth != 0) begin
          nest_depth--;
          // outermost end: close the group, a lone edit stays ungrouped
          if (nest_depth == 0) begin
            if (group_edits >= 2) slot_mark[top_slot] = GRP_END;
            else if (group_edits == 1) slot_mark[top_slot] = GRP_NONE;
            group_active = 1'b0;
            group_edits = '0;
          end
        end
      end
      CMD_UNDO: walk_group(1'b0);
      CMD_REDO: walk_group(1'b1);
      default: ;
    endcase
  endfunction

  // drive one request, wait for it to be taken, then queue what it should give
  task automatic issue_request(input cmd_item_t req, input bit typed, input res_item_t want);
    int held;
    bit ignored;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 23) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= req;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_ready !== 1'b1) @(posedge clk);
    ignored = (req.command > CMD_REDO) || (req.command == CMD_END && nest_depth == 0);
    held = pending_results.size();
    predict_step(req);
    if (typed) begin
      while (pending_results.size() > held) void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    if (!ignored) items_taken++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [ADDR_W-1:0] addr,
                          input logic [VAL_W-1:0] value);
    cmd_item_t req;
    req.command = code;
    req.tile_address = addr;
    req.tile_value = value;
    issue_request(req, 1'b0, UNTYPED);
  endtask

  // mostly a few hot tiles so reads and undos overlap, sometimes anywhere
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 3) != 0) return hot_addr[$urandom_range(0, 7)];
    return ADDR_W'($urandom_range(0, MAP - 1));
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    return VAL_W'($urandom);
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    res_item_t want;
    if (!rst && res_valid === 1'b1 && res_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status)
          report_error($sformatf("result %0d status got %0h want %0h",
                                 results_seen, res.status, want.status));
        if (res.out_address !== want.out_address)
          report_error($sformatf("result %0d out_address got %0h want %0h",
                                 results_seen, res.out_address, want.out_address));
        if (res.out_value !== want.out_value)
          report_error($sformatf("result %0d out_value got %0h want %0h",
                                 results_seen, res.out_value, want.out_value));
        if (res.last !== want.last)
          report_error($sformatf("result %0d last got %0b want %0b",
                                 results_seen, res.last, want.last));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[tb] no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("grouped_undo_redo_ring: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    int pick;
    bit extra;
    int long_groups;
    long_groups = 0;
    foreach (shadow_tiles[i]) shadow_tiles[i] = '0;
    foreach (slot_flag[i]) begin
      slot_flag[i] = FLAG_FREE;
      slot_mark[i] = GRP_NONE;
    end
    top_slot = RING - 1;
    nest_depth = '0;
    group_active = 1'b0;
    group_edits = '0;
    foreach (hot_addr[i]) hot_addr[i] = ADDR_W'($urandom_range(0, MAP - 1));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_table[i]) begin
      issue_request(directed_table[i].req, directed_table[i].typed, directed_table[i].want);
    end

    // nested groups unwind, then one end too many
    repeat (3) send_cmd(CMD_BEGIN, pick_addr(), rand_value());
    repeat (2) send_cmd(CMD_EDIT, pick_addr(), rand_value());
    repeat (4) send_cmd(CMD_END, pick_addr(), rand_value());
    send_cmd(CMD_UNDO, pick_addr(), rand_value());
    send_cmd(CMD_REDO, pick_addr(), rand_value());

    // random bursts, mostly well-formed groups and undo/redo runs
    items_taken = 0;
    while (items_taken < RANDOM_ITEMS) begin
      calm = (items_taken >= 140 && items_taken < 220);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        extra = ($urandom_range(0, 3) == 0);
        send_cmd(CMD_BEGIN, pick_addr(), rand_value());
        if (extra) send_cmd(CMD_BEGIN, pick_addr(), rand_value());
        repeat ($urandom_range(1, 5)) send_cmd(CMD_EDIT, pick_addr(), rand_value());
        repeat (1 + extra) send_cmd(CMD_END, pick_addr(), rand_value());
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 3)) send_cmd(CMD_EDIT, pick_addr(), rand_value());
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) send_cmd(CMD_UNDO, pick_addr(), rand_value());
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) send_cmd(CMD_REDO, pick_addr(), rand_value());
      end else if (pick < 90) begin
        send_cmd(CMD_READ, pick_addr(), rand_value());
      end else if (pick < 96) begin
        // noise: undecoded codes, stray ends, groups left open
        case ($urandom_range(0, 2))
          0: begin
            send_cmd($urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B,
                     ADDR_W'($urandom_range(0, MAP - 1)), rand_value());
          end
          1: begin
            send_cmd(CMD_END, pick_addr(), rand_value());
          end
          default: begin
            send_cmd(CMD_BEGIN, pick_addr(), rand_value());
          end
        endcase
      end else if (pick == 97 && long_groups < 3) begin
        // group around the ring size, wraps and may get cut short
        long_groups++;
        send_cmd(CMD_BEGIN, pick_addr(), rand_value());
        repeat ($urandom_range(RING - 4, RING + 6)) begin
          send_cmd(CMD_EDIT, pick_addr(), rand_value());
        end
        send_cmd(CMD_END, pick_addr(), rand_value());
        send_cmd(CMD_UNDO, pick_addr(), rand_value());
        send_cmd(CMD_REDO, pick_addr(), rand_value());
      end else begin
        send_cmd(CMD_READ, ADDR_W'($urandom_range(0, MAP - 1)), rand_value());
      end
    end
    calm = 1'b0;

    // drain
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("grouped_undo_redo_ring: match");
    end else begin
      $display("grouped_undo_redo_ring: mismatch");
    end
    $finish;
  end

endmodule
